// ----- sv/lidar_sector_avoidance_steering_unit_assert.svh -----
// Assertion macros for the lidar sector avoidance steering unit.
// Expects clk and rst_n in the scope of each use.
`ifndef LIDAR_SECTOR_AVOIDANCE_STEERING_UNIT_ASSERT_SVH
`define LIDAR_SECTOR_AVOIDANCE_STEERING_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define LSAS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define LSAS_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/lsas_pkg.sv -----
// Shared types and constants for the lidar sector avoidance steering unit.
// No dependencies.
`default_nettype none

package lsas_pkg;

    // Scan geometry
    localparam int SCAN_LENGTH = 360;
    localparam int RANGE_BITS  = 16;
    localparam int IDX_W       = $clog2(SCAN_LENGTH + 1);

    localparam logic [IDX_W-1:0] FRONT_LO = IDX_W'(340);
    localparam logic [IDX_W-1:0] FRONT_HI = IDX_W'(20);
    localparam logic [IDX_W-1:0] LEFT_LO  = IDX_W'(60);
    localparam logic [IDX_W-1:0] LEFT_HI  = IDX_W'(100);
    localparam logic [IDX_W-1:0] RIGHT_LO = IDX_W'(260);
    localparam logic [IDX_W-1:0] RIGHT_HI = IDX_W'(300);
    localparam logic [IDX_W-1:0] SCAN_END = IDX_W'(SCAN_LENGTH);

    // Field widths
    localparam int RANGE_W   = 16;
    localparam int THR_W     = 16;
    localparam int SPEED_W   = 10;
    localparam int TURN_W    = 15;
    localparam int GAIN_W    = 16;
    localparam int RATE_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int ERR_W     = RANGE_W + 1;
    localparam int GSUM_W    = GAIN_W + 2;
    localparam int PROD_W    = 36;
    localparam int FRAC_BITS = 12;

    localparam logic [RANGE_W-1:0] RANGE_MASK = RANGE_W'((64'd1 << RANGE_BITS) - 64'd1);

    // Output queue
    localparam int QDEPTH = 8;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GD    = 3'd6;

    typedef enum logic [1:0] {
        MODE_STRAIGHT = 2'd0,
        MODE_LEFT     = 2'd1,
        MODE_RIGHT    = 2'd2,
        MODE_OUT      = 2'd3
    } mode_t;

    typedef struct packed {
        logic [THR_W-1:0]   near_threshold_mm;
        logic [THR_W-1:0]   open_threshold_mm;
        logic [SPEED_W-1:0] forward_speed;
        logic [TURN_W-1:0]  turn_rate;
        logic [GAIN_W-1:0]  gain_proportional;
        logic [GAIN_W-1:0]  gain_sum;
        logic [GAIN_W-1:0]  gain_difference;
    } cfg_t;

    // End-of-scan decision handed from the sector stage to the steering stage
    typedef struct packed {
        logic                    valid;
        mode_t                   mode;
        logic signed [ERR_W-1:0] err;
        logic signed [ERR_W-1:0] prev_err;
    } scan_t;

    typedef struct packed {
        logic [SPEED_W-1:0]       speed;
        logic signed [RATE_W-1:0] rate;
        mode_t                    mode;
    } cmd_t;

endpackage

`default_nettype wire

// ----- sv/lidar_sector_avoidance_steering_unit.sv -----
// Lidar sector avoidance steering unit: one range sample per cycle, one command per scan.
// A command passes the input register, the scan decision register, the product registers and the queue.
// Throughput: one sample per cycle; samples stall only while 8 commands are awaiting delivery,
// which is the depth of the output queue.
// Reset (rst_n, async): registers to defaults, minima to all ones, mode straight, queue empty.
// Depends on lsas_pkg, lsas_sector, lsas_steer, lsas_queue and the assertion header.
`default_nettype none

`include "lidar_sector_avoidance_steering_unit_assert.svh"

module lidar_sector_avoidance_steering_unit import lsas_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     sample_valid,
    output logic                     sample_stall,
    input  logic [RANGE_W-1:0]       range_mm,
    input  logic                     last_of_scan,
    output logic                     cmd_valid,
    input  logic                     cmd_stall,
    output logic [SPEED_W-1:0]       linear_speed,
    output logic signed [RATE_W-1:0] angular_rate,
    output logic [1:0]               mode
);

    cfg_t               cfg_reg;
    logic               in_valid_reg;
    logic [RANGE_W-1:0] in_range_reg;
    logic               in_last_reg;
    logic [QCNT_W-1:0]  pending_reg;
    logic [QCNT_W-1:0]  pending_next;

    logic               accept;
    logic               accept_last;
    logic               cmd_pop;
    scan_t              scan;
    logic               push;
    cmd_t               push_cmd;
    cmd_t               head;
    logic [QCNT_W-1:0]  queue_count;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_threshold_mm <= THR_W'(400);
            cfg_reg.open_threshold_mm <= THR_W'(1000);
            cfg_reg.forward_speed     <= SPEED_W'(100);
            cfg_reg.turn_rate         <= TURN_W'(1300);
            cfg_reg.gain_proportional <= GAIN_W'(819);
            cfg_reg.gain_sum          <= GAIN_W'(41);
            cfg_reg.gain_difference   <= GAIN_W'(8192);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NEAR:  cfg_reg.near_threshold_mm <= cfg_data;
                CFG_OPEN:  cfg_reg.open_threshold_mm <= cfg_data;
                CFG_SPEED: cfg_reg.forward_speed     <= cfg_data[SPEED_W-1:0];
                CFG_TURN:  cfg_reg.turn_rate         <= cfg_data[TURN_W-1:0];
                CFG_GP:    cfg_reg.gain_proportional <= cfg_data;
                CFG_GS:    cfg_reg.gain_sum          <= cfg_data;
                CFG_GD:    cfg_reg.gain_difference   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Each accepted end-of-scan transaction reserves one queue slot until delivered
    assign accept       = sample_valid && !sample_stall;
    assign accept_last  = accept && last_of_scan;
    assign cmd_pop      = cmd_valid && !cmd_stall;
    assign sample_stall = pending_reg == QCNT_W'(QDEPTH);

    always_comb
    begin
        pending_next = pending_reg;
        if (accept_last && !cmd_pop)
            pending_next = pending_reg + 1'b1;
        else if (cmd_pop && !accept_last)
            pending_next = pending_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= '0;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg  <= pending_next;
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_range_reg <= range_mm;
            in_last_reg  <= last_of_scan;
        end
    end

    lsas_sector u_sector (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .smp_valid (in_valid_reg),
        .smp_range (in_range_reg),
        .smp_last  (in_last_reg),
        .scan      (scan)
    );

    lsas_steer u_steer (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .scan  (scan),
        .push  (push),
        .cmd   (push_cmd)
    );

    lsas_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (cmd_pop),
        .valid    (cmd_valid),
        .head     (head),
        .count    (queue_count)
    );

    assign linear_speed = head.speed;
    assign angular_rate = head.rate;
    assign mode         = head.mode;

    `LSAS_ASSERT_IMP(a_queue_credit, 1'b1, queue_count <= pending_reg, "queue holds more than reserved")
    `LSAS_ASSERT_IMP(a_turn_speed, cmd_valid && mode != MODE_STRAIGHT, linear_speed == '0, "speed while not straight")
    `LSAS_ASSERT_IMP(a_out_rate, cmd_valid && mode == MODE_OUT, angular_rate == '0, "rate while out of maze")
    `LSAS_ASSERT_NXT(a_fill_stall, accept_last && !cmd_pop && pending_reg == QCNT_W'(QDEPTH - 1), sample_stall, "no stall when queue reservations run out")

endmodule

`default_nettype wire

// ----- sv/lsas_sector.sv -----
// Sample index, sector minima and robot mode; emits one decision per scan.
// Depends on lsas_pkg.
`default_nettype none

module lsas_sector import lsas_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               smp_valid,
    input  logic [RANGE_W-1:0] smp_range,
    input  logic               smp_last,
    output scan_t              scan
);

    logic [IDX_W-1:0]        idx_reg;
    logic [RANGE_W-1:0]      fmin_reg;
    logic [RANGE_W-1:0]      lmin_reg;
    logic [RANGE_W-1:0]      rmin_reg;
    mode_t                   mode_reg;
    logic signed [ERR_W-1:0] prev_reg;
    scan_t                   scan_reg;

    logic [IDX_W-1:0]        idx_next;
    logic [RANGE_W-1:0]      fmin_next;
    logic [RANGE_W-1:0]      lmin_next;
    logic [RANGE_W-1:0]      rmin_next;
    mode_t                   mode_next;
    logic signed [ERR_W-1:0] err;
    logic [RANGE_W-1:0]      r;
    logic                    in_scan;
    logic                    is_front;
    logic                    is_left;
    logic                    is_right;

    always_comb
    begin
        r        = smp_range & RANGE_MASK;
        in_scan  = idx_reg < SCAN_END;
        is_front = (idx_reg >= FRONT_LO) || (idx_reg < FRONT_HI);
        is_left  = (idx_reg >= LEFT_LO) && (idx_reg < LEFT_HI);
        is_right = (idx_reg >= RIGHT_LO) && (idx_reg < RIGHT_HI);

        fmin_next = (in_scan && is_front && r < fmin_reg) ? r : fmin_reg;
        lmin_next = (in_scan && is_left && r < lmin_reg) ? r : lmin_reg;
        rmin_next = (in_scan && is_right && r < rmin_reg) ? r : rmin_reg;
        idx_next  = in_scan ? idx_reg + 1'b1 : idx_reg;

        mode_next = mode_reg;
        unique case (mode_reg) inside
            MODE_STRAIGHT:
            begin
                if (fmin_next < cfg.near_threshold_mm)
                    mode_next = (lmin_next < rmin_next) ? MODE_RIGHT : MODE_LEFT;
            end
            MODE_LEFT, MODE_RIGHT:
            begin
                if (fmin_next > cfg.near_threshold_mm)
                    mode_next = MODE_STRAIGHT;
            end
            default:
            begin
            end
        endcase

        // Wide open on all sides: out of the maze
        if (fmin_next > cfg.open_threshold_mm && lmin_next > cfg.open_threshold_mm &&
            rmin_next > cfg.open_threshold_mm)
            mode_next = MODE_OUT;
        // Open ahead with walls on both sides: corridor, drive straight
        if (fmin_next > cfg.open_threshold_mm && lmin_next < cfg.open_threshold_mm &&
            rmin_next < cfg.open_threshold_mm)
            mode_next = MODE_STRAIGHT;

        err = $signed({1'b0, lmin_next}) - $signed({1'b0, rmin_next});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            fmin_reg <= RANGE_MASK;
            lmin_reg <= RANGE_MASK;
            rmin_reg <= RANGE_MASK;
            mode_reg <= MODE_STRAIGHT;
            prev_reg <= '0;
            scan_reg <= '0;
        end
        else
        begin
            scan_reg.valid    <= smp_valid && smp_last;
            scan_reg.mode     <= mode_next;
            scan_reg.err      <= err;
            scan_reg.prev_err <= prev_reg;
            if (smp_valid)
            begin
                if (smp_last)
                begin
                    mode_reg <= mode_next;
                    if (mode_next == MODE_STRAIGHT)
                        prev_reg <= err;
                    // Start the next scan
                    idx_reg  <= '0;
                    fmin_reg <= RANGE_MASK;
                    lmin_reg <= RANGE_MASK;
                    rmin_reg <= RANGE_MASK;
                end
                else
                begin
                    idx_reg  <= idx_next;
                    fmin_reg <= fmin_next;
                    lmin_reg <= lmin_next;
                    rmin_reg <= rmin_next;
                end
            end
        end
    end

    assign scan = scan_reg;

endmodule

`default_nettype wire

// ----- sv/lsas_steer.sv -----
// Steering command: Q4.12 gain products, rounding, saturation and mode select.
// Depends on lsas_pkg.
`default_nettype none

module lsas_steer import lsas_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  scan_t scan,
    output logic  push,
    output cmd_t  cmd
);

    // Gp*e + Gs*(e+p) + Gd*(e-p) = (Gp+Gs+Gd)*e + (Gs-Gd)*p
    logic [GSUM_W-1:0]        gain_e;
    logic signed [ERR_W-1:0]  gain_p;
    logic signed [PROD_W-1:0] prod_e;
    logic signed [PROD_W-1:0] prod_p;

    logic                     valid_reg;
    mode_t                    mode_reg;
    logic signed [PROD_W-1:0] prod_e_reg;
    logic signed [PROD_W-1:0] prod_p_reg;

    logic signed [PROD_W-1:0] acc;
    logic signed [PROD_W-1:0] quot;
    logic signed [RATE_W-1:0] pid_rate;
    logic signed [RATE_W-1:0] turn;

    always_comb
    begin
        gain_e = GSUM_W'(cfg.gain_proportional) + GSUM_W'(cfg.gain_sum)
               + GSUM_W'(cfg.gain_difference);
        gain_p = $signed({1'b0, cfg.gain_sum}) - $signed({1'b0, cfg.gain_difference});
        prod_e = $signed({1'b0, gain_e}) * scan.err;
        prod_p = gain_p * scan.prev_err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= scan.valid;
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= scan.mode;
        prod_e_reg <= prod_e;
        prod_p_reg <= prod_p;
    end

    always_comb
    begin
        // Round half up, then floor by arithmetic shift
        acc  = prod_e_reg + prod_p_reg + PROD_W'(2048);
        quot = acc >>> FRAC_BITS;
        if (quot > PROD_W'(32767))
            pid_rate = 16'sh7FFF;
        else if (quot < -PROD_W'(32768))
            pid_rate = 16'sh8000;
        else
            pid_rate = quot[RATE_W-1:0];

        turn = $signed({1'b0, cfg.turn_rate});

        cmd.mode  = mode_reg;
        cmd.speed = '0;
        case (mode_reg)
            MODE_STRAIGHT:
            begin
                cmd.speed = cfg.forward_speed;
                cmd.rate  = pid_rate;
            end
            MODE_LEFT:  cmd.rate = turn;
            MODE_RIGHT: cmd.rate = -turn;
            default:    cmd.rate = '0;
        endcase
    end

    assign push = valid_reg;

endmodule

`default_nettype wire

// ----- sv/lsas_queue.sv -----
// Output queue for steering commands, flop array with count.
// Depends on lsas_pkg.
`default_nettype none

module lsas_queue import lsas_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cmd_t              push_cmd,
    input  logic              pop,
    output logic              valid,
    output cmd_t              head,
    output logic [QCNT_W-1:0] count
);

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    assign valid = count_reg != '0;
    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

`default_nettype wire

// ----- tb/sv/lidar_sector_avoidance_steering_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench for lidar_sector_avoidance_steering_unit: streams lidar scans into the sample
// channel, predicts the steering command of every scan and checks it on the command channel.
// Depends on lsas_pkg and the unit under test only.

module lidar_sector_avoidance_steering_unit_tb;
    import lsas_pkg::*;

    localparam int     RANGE_TOP     = (1 << RANGE_W) - 1;
    localparam int     NUM_REGS      = 1 << CFG_IDX_W;
    localparam int     STUCK_LIMIT   = 5000;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     ITEMS_GOAL    = 300;
    localparam int     SCANS_GOAL    = 2;
    localparam int     MAX_REPORTS   = 10;
    localparam longint RATE_MAX      = (longint'(1) <<< (RATE_W - 1)) - 1;
    localparam longint RATE_MIN      = -(longint'(1) <<< (RATE_W - 1));
    localparam longint HALF_LSB      = longint'(1) <<< (FRAC_BITS - 1);

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_W-1:0]         cfg_data;
    logic                     sample_valid;
    logic                     sample_stall;
    logic [RANGE_W-1:0]       range_mm;
    logic                     last_of_scan;
    logic                     cmd_valid;
    logic                     cmd_stall;
    logic [SPEED_W-1:0]       linear_speed;
    logic signed [RATE_W-1:0] angular_rate;
    logic [1:0]               mode;

    // Predicted copy of the registers and of the scan state
    logic [THR_W-1:0]   near_mm;
    logic [THR_W-1:0]   open_mm;
    logic [SPEED_W-1:0] fwd_speed;
    logic [TURN_W-1:0]  turn_mrad;
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_s;
    logic [GAIN_W-1:0]  gain_d;
    int                 scan_idx;
    logic [RANGE_W-1:0] front_lo;
    logic [RANGE_W-1:0] left_lo;
    logic [RANGE_W-1:0] right_lo;
    mode_t              heading;
    longint             prev_err;

    cmd_t               pending_cmds [$];
    logic [CFG_W-1:0]   next_regs [NUM_REGS];

    int items_sent   = 0;
    int scans_closed = 0;
    int mismatches   = 0;
    int stuck_cycles = 0;
    int rx_hold      = 0;
    bit tx_gaps      = 1'b1;
    bit rx_gaps      = 1'b1;

    lidar_sector_avoidance_steering_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .range_mm     (range_mm),
        .last_of_scan (last_of_scan),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .linear_speed (linear_speed),
        .angular_rate (angular_rate),
        .mode         (mode)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void open_new_scan();
        scan_idx = 0;
        front_lo = '1;
        left_lo  = '1;
        right_lo = '1;
    endfunction

    // Fold one accepted sample into the sector minima; close the scan on its last sample
    function automatic void advance_scan(input logic [RANGE_W-1:0] sample, input logic last);
        logic [RANGE_W-1:0] r;
        longint             err;
        longint             acc;
        longint             rate;
        cmd_t               cmd;
        r = sample & RANGE_MASK;
        if (scan_idx < SCAN_LENGTH)
        begin
            if ((scan_idx >= int'(FRONT_LO) || scan_idx < int'(FRONT_HI)) && r < front_lo)
                front_lo = r;
            if (scan_idx >= int'(LEFT_LO) && scan_idx < int'(LEFT_HI) && r < left_lo)
                left_lo = r;
            if (scan_idx >= int'(RIGHT_LO) && scan_idx < int'(RIGHT_HI) && r < right_lo)
                right_lo = r;
            scan_idx++;
        end
        if (last)
        begin
            case (heading)
                MODE_STRAIGHT:
                    if (front_lo < near_mm)
                        heading = (left_lo < right_lo) ? MODE_RIGHT : MODE_LEFT;
                MODE_LEFT, MODE_RIGHT:
                    if (front_lo > near_mm)
                        heading = MODE_STRAIGHT;
                default: ;
            endcase
            // Out-of-maze override first, then the corridor override wins
            if (front_lo > open_mm && left_lo > open_mm && right_lo > open_mm)
                heading = MODE_OUT;
            if (front_lo > open_mm && left_lo < open_mm && right_lo < open_mm)
                heading = MODE_STRAIGHT;

            cmd.speed = '0;
            case (heading)
                MODE_STRAIGHT:
                begin
                    err = longint'(left_lo) - longint'(right_lo);
                    acc = longint'(gain_p) * err + longint'(gain_s) * (err + prev_err)
                        + longint'(gain_d) * (err - prev_err);
                    rate = (acc + HALF_LSB) >>> FRAC_BITS;
                    if (rate > RATE_MAX)
                        rate = RATE_MAX;
                    if (rate < RATE_MIN)
                        rate = RATE_MIN;
                    prev_err  = err;
                    cmd.speed = fwd_speed;
                end
                MODE_LEFT:  rate = longint'(turn_mrad);
                MODE_RIGHT: rate = -longint'(turn_mrad);
                default:    rate = 0;
            endcase
            cmd.rate = rate[RATE_W-1:0];
            cmd.mode = heading;
            pending_cmds.push_back(cmd);
            scans_closed++;
            open_new_scan();
        end
    endfunction

    task automatic send_sample(input logic [RANGE_W-1:0] r, input logic last);
        if (tx_gaps && $urandom_range(0, 99) < 10)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        range_mm     <= r;
        last_of_scan <= last;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        advance_scan(r, last);
        items_sent++;
    endtask

    // Drop valid, drain every pending command, then let the pipeline settle
    task automatic wait_idle();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= next_regs[i];
            @(posedge clk);
            case (CFG_IDX_W'(i))
                CFG_NEAR:  near_mm   = next_regs[i];
                CFG_OPEN:  open_mm   = next_regs[i];
                CFG_SPEED: fwd_speed = next_regs[i][SPEED_W-1:0];
                CFG_TURN:  turn_mrad = next_regs[i][TURN_W-1:0];
                CFG_GP:    gain_p    = next_regs[i];
                CFG_GS:    gain_s    = next_regs[i];
                CFG_GD:    gain_d    = next_regs[i];
                default: ;
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    // Sector floor near the interesting thresholds, or anywhere
    function automatic logic [RANGE_W-1:0] pick_level();
        int t;
        case ($urandom_range(0, 9))
            0:       t = int'(near_mm) - 1;
            1:       t = int'(near_mm);
            2:       t = int'(near_mm) + 1;
            3:       t = int'(open_mm) - 1;
            4:       t = int'(open_mm);
            5:       t = int'(open_mm) + 1;
            6:       t = 0;
            7:       t = RANGE_TOP;
            default: t = int'($urandom_range(0, RANGE_TOP));
        endcase
        if (t < 0)
            t = 0;
        if (t > RANGE_TOP)
            t = RANGE_TOP;
        return RANGE_W'(t);
    endfunction

    task automatic send_random_scan();
        int                 len;
        int                 pick;
        int                 tmp;
        bit                 in_sector;
        logic [RANGE_W-1:0] f_lvl;
        logic [RANGE_W-1:0] l_lvl;
        logic [RANGE_W-1:0] r_lvl;
        logic [RANGE_W-1:0] lvl;
        logic [RANGE_W-1:0] v;
        pick = int'($urandom_range(0, 99));
        if (pick < 70)
            len = SCAN_LENGTH;
        else if (pick < 85)
            len = int'($urandom_range(1, SCAN_LENGTH - 1));
        else
            len = int'($urandom_range(SCAN_LENGTH + 1, SCAN_LENGTH + 60));
        if ($urandom_range(0, 3) == 0)
        begin
            // corridor: open ahead, both walls closer than the open threshold
            f_lvl = (open_mm == '1) ? '1
                  : RANGE_W'($urandom_range(int'(open_mm) + 1, RANGE_TOP));
            l_lvl = (open_mm == '0) ? '0 : RANGE_W'($urandom_range(0, int'(open_mm) - 1));
            r_lvl = (open_mm == '0) ? '0 : RANGE_W'($urandom_range(0, int'(open_mm) - 1));
        end
        else
        begin
            f_lvl = pick_level();
            l_lvl = pick_level();
            r_lvl = pick_level();
        end
        for (int i = 0; i < len; i++)
        begin
            in_sector = 1'b1;
            lvl       = '0;
            if (i >= SCAN_LENGTH)
                in_sector = 1'b0;
            else if (i >= int'(FRONT_LO) || i < int'(FRONT_HI))
                lvl = f_lvl;
            else if (i >= int'(LEFT_LO) && i < int'(LEFT_HI))
                lvl = l_lvl;
            else if (i >= int'(RIGHT_LO) && i < int'(RIGHT_HI))
                lvl = r_lvl;
            else
                in_sector = 1'b0;
            if (!in_sector)
                v = RANGE_W'($urandom);
            else if ($urandom_range(0, 7) == 0)
                v = lvl;
            else
            begin
                tmp = int'(lvl) + int'($urandom_range(0, 4000));
                v   = (tmp > RANGE_TOP) ? '1 : RANGE_W'(tmp);
            end
            send_sample(v, i == len - 1);
        end
    endtask

    // Short scans under reset settings: only the front sector is seen, side sectors stay empty
    task automatic test_directed_modes();
        send_sample(RANGE_W'(400), 1'b0);
        send_sample('1, 1'b0);
        send_sample(RANGE_W'(700), 1'b1);
        send_sample(RANGE_W'(399), 1'b1);
        send_sample(RANGE_W'(400), 1'b1);
        send_sample(RANGE_W'(401), 1'b1);
        send_sample(RANGE_W'(1000), 1'b1);
        send_sample('0, 1'b1);
        send_sample(RANGE_W'(1001), 1'b1);
        send_sample('0, 1'b1);
        send_sample('1, 1'b1);
    endtask

    task automatic test_config_extremes();
        wait_idle();
        foreach (next_regs[i])
            next_regs[i] = '0;
        write_regs();
        send_random_scan();
        wait_idle();
        foreach (next_regs[i])
            next_regs[i] = '1;
        write_regs();
        send_random_scan();
    endtask

    task automatic test_back_to_back();
        wait_idle();
        next_regs[CFG_NEAR]     = CFG_W'(400);
        next_regs[CFG_OPEN]     = CFG_W'(1000);
        next_regs[CFG_SPEED]    = CFG_W'(100);
        next_regs[CFG_TURN]     = CFG_W'(1300);
        next_regs[CFG_GP]       = CFG_W'(819);
        next_regs[CFG_GS]       = CFG_W'(41);
        next_regs[CFG_GD]       = CFG_W'(8192);
        next_regs[NUM_REGS - 1] = CFG_W'($urandom);
        write_regs();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        repeat (2) send_random_scan();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    // Hold off the command side while one-sample scans keep arriving
    task automatic test_output_backpressure();
        rx_hold = HOLD_CYCLES;
        repeat (40) send_sample(RANGE_W'($urandom), 1'b1);
    endtask

    task automatic test_random_scans();
        int start_items;
        int start_scans;
        start_items = items_sent;
        start_scans = scans_closed;
        while (items_sent - start_items < ITEMS_GOAL || scans_closed - start_scans < SCANS_GOAL)
        begin
            wait_idle();
            next_regs[CFG_NEAR] = CFG_W'($urandom_range(50, 2500));
            if ($urandom_range(0, 4) == 0)
                next_regs[CFG_OPEN] = CFG_W'($urandom);
            else
                next_regs[CFG_OPEN] = next_regs[CFG_NEAR] + CFG_W'($urandom_range(0, 3000));
            next_regs[CFG_SPEED] = CFG_W'($urandom);
            next_regs[CFG_TURN]  = CFG_W'($urandom);
            for (int g = int'(CFG_GP); g <= int'(CFG_GD); g++)
                next_regs[g] = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom)
                             : CFG_W'($urandom_range(0, 8192));
            next_regs[NUM_REGS - 1] = CFG_W'($urandom);
            write_regs();
            repeat ($urandom_range(1, 2)) send_random_scan();
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        sample_valid <= 1'b0;
        range_mm     <= '0;
        last_of_scan <= 1'b0;
        near_mm   = THR_W'(400);
        open_mm   = THR_W'(1000);
        fwd_speed = SPEED_W'(100);
        turn_mrad = TURN_W'(1300);
        gain_p    = GAIN_W'(819);
        gain_s    = GAIN_W'(41);
        gain_d    = GAIN_W'(8192);
        heading   = MODE_STRAIGHT;
        prev_err  = 0;
        open_new_scan();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_modes();
        test_config_extremes();
        test_back_to_back();
        test_output_backpressure();
        test_random_scans();

        sample_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Command receiver: random stalls, plus a long hold-off on request
    initial
    begin
        cmd_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                cmd_stall <= 1'b1;
                rx_hold--;
            end
            else
                cmd_stall <= rx_gaps && ($urandom_range(0, 99) < 10);
        end
    end

    always @(posedge clk)
    begin : cmd_check
        cmd_t want;
        if (rst_n && cmd_valid && !cmd_stall)
        begin
            if (pending_cmds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: command with none pending: speed %0d rate %0d mode %0d",
                             $time, linear_speed, angular_rate, mode);
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (linear_speed !== want.speed || angular_rate !== want.rate
                    || mode !== want.mode)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: expected speed %0d rate %0d mode %0d, %s %0d %0d %0d",
                                 $time, want.speed, want.rate, want.mode,
                                 "got speed/rate/mode", linear_speed, angular_rate, mode);
                end
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (cmd_valid && !cmd_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

endmodule
